FILE: src/wbce_pkg.sv
// Package of the weighted branch confidence estimator.
// Holds widths, opcodes, register indexes, the controller command and status types
// and the fixed-point helpers. It depends on nothing.
package wbce_pkg;

  // Score format: unsigned Q(SCORE_INT_BITS).(SCORE_FRAC_BITS), saturating.
  localparam int SCORE_FRAC_BITS = 8;
  localparam int SCORE_INT_BITS  = 12;
  localparam int SCORE_W         = SCORE_INT_BITS + SCORE_FRAC_BITS;

  // Miss rate is unsigned Q1.8 held in 9 bits (256 stands for 1.0).
  localparam int RATE_FRAC = 8;
  localparam int RATE_W    = RATE_FRAC + 1;
  localparam int WEIGHT_W  = 8;
  localparam int PROD_W    = WEIGHT_W + RATE_W;

  // Extra term after alignment to the score fraction.
  localparam int EXTRA_W = (SCORE_FRAC_BITS >= RATE_FRAC) ?
                           PROD_W + SCORE_FRAC_BITS - RATE_FRAC :
                           PROD_W - (RATE_FRAC - SCORE_FRAC_BITS);

  // Configuration register widths.
  localparam int THR_W    = 12;
  localparam int INCR_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Working width of the update sums: wide enough for any operand plus carries.
  localparam int MAX_A  = (SCORE_W > EXTRA_W) ? SCORE_W : EXTRA_W;
  localparam int MAX_B  = (MAX_A > THR_W + SCORE_FRAC_BITS) ? MAX_A : THR_W + SCORE_FRAC_BITS;
  localparam int SUM_W  = MAX_B + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Divider: (miss_count << 8) / period, one quotient bit per step.
  localparam int DIVIDEND_W = COUNT_W + RATE_FRAC;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_FRAC;

  // Opcodes of an input item.
  localparam logic [2:0] OP_ORDINARY      = 3'd0;
  localparam logic [2:0] OP_CONTROL_FLOW  = 3'd1;
  localparam logic [2:0] OP_TICK          = 3'd2;
  localparam logic [2:0] OP_RECOVER       = 3'd3;
  localparam logic [2:0] OP_PERFECT_RESET = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_DISABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CF_DISABLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_INCR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_WEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic calc;       // register the weighted miss-rate term, arm the divider
    logic div_step;   // one restoring division step
    logic apply;      // commit the state update and write the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div;  // item is a tick at the start of a sampling window
    logic out_free;   // result register can take a new result
  } dp_status_t;

  // Align the Q.8 product to the score fraction.
  function automatic logic [SUM_W-1:0] align_extra(input logic [PROD_W-1:0] p);
    logic [SUM_W-1:0] w;
    w = SUM_W'(p);
    if (SCORE_FRAC_BITS >= RATE_FRAC) begin
      return w << ((SCORE_FRAC_BITS >= RATE_FRAC) ? SCORE_FRAC_BITS - RATE_FRAC : 0);
    end else begin
      return w >> ((SCORE_FRAC_BITS < RATE_FRAC) ? RATE_FRAC - SCORE_FRAC_BITS : 0);
    end
  endfunction

  // Clamp a working sum to the score range.
  function automatic logic [SCORE_W-1:0] sat_score(input logic [SUM_W-1:0] s);
    if (s > SUM_W'(SCORE_MAX)) begin
      return SCORE_MAX;
    end else begin
      return s[SCORE_W-1:0];
    end
  endfunction

endpackage

FILE: src/wbce_if.sv
// Item channel interfaces of the weighted branch confidence estimator.
// Valid/ready channels for input events and results; uses no package.
interface wbce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic       is_control_flow;
  logic [1:0] branch_confidence;
  logic       was_btb_miss;

  modport source (output valid, output opcode, output is_control_flow,
                  output branch_confidence, output was_btb_miss, input ready);
  modport sink   (input valid, input opcode, input is_control_flow,
                  input branch_confidence, input was_btb_miss, output ready);
endinterface

interface wbce_out_if;
  logic valid;
  logic ready;
  logic threshold_hit;

  modport source (output valid, output threshold_hit, input ready);
  modport sink   (input valid, input threshold_hit, output ready);
endinterface

FILE: src/weighted_branch_confidence_estimator.sv
// Top level of the weighted branch confidence estimator.
// Joins wbce_ctrl and wbce_datapath to the item channels; uses wbce_pkg and wbce_if.
//
// Each input item is one front-end event (ordinary op, control-flow op, tick,
// recovery or perfect reset) and yields exactly one result item carrying
// threshold_hit. An item goes through accept, weighted miss-rate multiply and
// update before the next acceptance, and the update waits while the result register
// is full; a tick that opens a sampling window also runs a restoring divider for the
// new miss rate, which produces one of its 24 quotient bits per cycle. A finished result
// sits in an output register, so the next item is accepted while it waits to be taken.
// Configuration registers are written through cfg_we_i, cfg_index_i and cfg_data_i;
// the user writes them only while the block is idle; the block does not enforce it.
module weighted_branch_confidence_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbce_pkg::CFG_W-1:0]      cfg_data_i,
  wbce_in_if.sink                         in_i,
  wbce_out_if.source                      out_o
);
  import wbce_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequencer.
  wbce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath.
  wbce_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (in_i.opcode),
    .is_control_flow_i   (in_i.is_control_flow),
    .branch_confidence_i (in_i.branch_confidence),
    .was_btb_miss_i      (in_i.was_btb_miss),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .threshold_hit_o     (out_o.threshold_hit)
  );

endmodule

FILE: src/wbce_ctrl.sv
// Controller of the weighted branch confidence estimator.
// Sequences accept, term calculation, serial division and update; uses wbce_pkg.
module wbce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wbce_pkg::dp_status_t  status_i,
  output wbce_pkg::ctrl_cmd_t   cmd_o
);
  import wbce_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        cnt_d      = '0;
        state_d    = status_i.needs_div ? ST_DIV : ST_APPLY;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (status_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: src/wbce_datapath.sv
// Datapath of the weighted branch confidence estimator.
// Holds configuration, score state, the miss-rate multiplier and serial divider,
// and the result register; uses wbce_pkg.
module wbce_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbce_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [2:0]                      opcode_i,
  input  logic                            is_control_flow_i,
  input  logic [1:0]                      branch_confidence_i,
  input  logic                            was_btb_miss_i,
  input  wbce_pkg::ctrl_cmd_t             cmd_i,
  output wbce_pkg::dp_status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            threshold_hit_o
);
  import wbce_pkg::*;

  // Configuration registers.
  logic                 dist_dis_q, cf_dis_q;
  logic [THR_W-1:0]     thr_q;
  logic [INCR_W-1:0]    incr_q;
  logic [WEIGHT_W-1:0]  weight_q;
  logic [PERIOD_W-1:0]  period_q;

  // Captured item.
  logic [2:0] op_q;
  logic       is_cf_q;
  logic [1:0] conf_q;
  logic       btb_q;

  // Estimator state.
  logic [SCORE_W-1:0]  score_q, score_d;
  logic [SCORE_W-1:0]  dist_q, dist_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [COUNT_W-1:0]  miss_q, miss_d;
  logic [PERIOD_W-1:0] phase_q, phase_d;
  logic [SUM_W-1:0]    extra_q;

  // Divider registers.
  logic [PERIOD_W-1:0]   rem_q;
  logic [DIVIDEND_W-1:0] quo_q;

  // Result register.
  logic out_valid_q, hit_q, hit_d;

  logic [PERIOD_W-1:0] per_eff;
  logic [SUM_W-1:0]    thr_fix;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   phase_inc;

  assign per_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign thr_fix = SUM_W'(thr_q) << SCORE_FRAC_BITS;

  assign status_o.needs_div = (op_q == OP_TICK) && (phase_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_dis_q <= 1'b0;
      cf_dis_q   <= 1'b0;
      thr_q      <= THR_W'(8);
      incr_q     <= INCR_W'(1);
      weight_q   <= '0;
      period_q   <= PERIOD_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIST_DISABLE: dist_dis_q <= cfg_data_i[0];
        CFG_CF_DISABLE:   cf_dis_q   <= cfg_data_i[0];
        CFG_THRESHOLD:    thr_q      <= cfg_data_i[THR_W-1:0];
        CFG_DIST_INCR:    incr_q     <= cfg_data_i[INCR_W-1:0];
        CFG_MISS_WEIGHT:  weight_q   <= cfg_data_i[WEIGHT_W-1:0];
        CFG_PERIOD:       period_q   <= cfg_data_i[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture and weighted miss-rate term.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      is_cf_q <= is_control_flow_i;
      conf_q  <= branch_confidence_i;
      btb_q   <= was_btb_miss_i;
    end
    if (cmd_i.calc) begin
      extra_q <= align_extra(PROD_W'(weight_q) * PROD_W'(rate_q));
    end
  end

  // Restoring divider: one quotient bit per step.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      rem_q <= '0;
      quo_q <= {miss_q, {RATE_FRAC{1'b0}}};
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, per_eff}) begin
        rem_q <= PERIOD_W'(trial - {1'b0, per_eff});
        quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[PERIOD_W-1:0];
        quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  // Event update.
  assign phase_inc = {1'b0, phase_q} + (PERIOD_W + 1)'(1);

  always_comb begin
    score_d = score_q;
    dist_d  = dist_q;
    rate_d  = rate_q;
    miss_d  = miss_q;
    phase_d = phase_q;
    hit_d   = 1'b0;
    unique case (op_q)
      OP_ORDINARY: begin
        if (!dist_dis_q && !is_cf_q) begin
          if (SUM_W'(dist_q) >= thr_fix) begin
            score_d = sat_score(SUM_W'(score_q) + (SUM_W'(incr_q) << SCORE_FRAC_BITS)
                                + extra_q);
            dist_d  = '0;
          end else begin
            dist_d  = sat_score(SUM_W'(dist_q) + (SUM_W'(1) << SCORE_FRAC_BITS)
                                + extra_q);
          end
        end
        hit_d = (SUM_W'(score_d) >= thr_fix);
      end
      OP_CONTROL_FLOW: begin
        if (!cf_dis_q) begin
          score_d = sat_score(SUM_W'(score_q)
                              + (SUM_W'(2'd3 - conf_q) << SCORE_FRAC_BITS) + extra_q);
          dist_d  = '0;
        end
        hit_d = (SUM_W'(score_d) >= thr_fix);
      end
      OP_TICK: begin
        // At the window start the rate is resampled from the divider result.
        if (phase_q == '0) begin
          rate_d = (quo_q > DIVIDEND_W'(RATE_ONE)) ? RATE_ONE : quo_q[RATE_W-1:0];
          miss_d = '0;
        end
        phase_d = (phase_inc >= {1'b0, per_eff}) ? '0 : phase_inc[PERIOD_W-1:0];
      end
      OP_RECOVER: begin
        if (btb_q && (miss_q != {COUNT_W{1'b1}})) begin
          miss_d = miss_q + COUNT_W'(1);
        end
        score_d = '0;
        dist_d  = '0;
      end
      OP_PERFECT_RESET: begin
        dist_d = '0;
      end
      default: begin
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q     <= '0;
      dist_q      <= '0;
      rate_q      <= '0;
      miss_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        score_q     <= score_d;
        dist_q      <= dist_d;
        rate_q      <= rate_d;
        miss_q      <= miss_d;
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign threshold_hit_o = hit_q;

endmodule

FILE: bench/weighted_branch_confidence_estimator_test.sv
// Self-checking bench of weighted_branch_confidence_estimator: directed events, then random
// events under several register settings, each result checked against an in-bench estimator
// or a fixed expectation. Depends on wbce_pkg, wbce_in_if, wbce_out_if and the block itself.
module weighted_branch_confidence_estimator_test;
  import wbce_pkg::*;

  // Opcodes that the block must treat as no-ops.
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MISS_BURST      = 40;

  typedef struct packed {
    logic [2:0] opcode;
    logic       is_cf;
    logic [1:0] conf;
    logic       miss;
  } fe_event_t;

  // One row of the directed part: an event, how often it is sent, and a fixed
  // expectation where one is given.
  typedef struct packed {
    logic [2:0] opcode;
    logic       is_cf;
    logic [1:0] conf;
    logic       miss;
    logic [3:0] reps;
    logic       known;
    logic       hit;
  } script_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  wbce_in_if  in_if ();
  wbce_out_if out_if ();

  weighted_branch_confidence_estimator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Register copies kept by the bench.
  logic                set_dist_off;
  logic                set_cf_off;
  logic [THR_W-1:0]    set_threshold;
  logic [INCR_W-1:0]   set_increment;
  logic [WEIGHT_W-1:0] set_weight;
  logic [PERIOD_W-1:0] set_period;

  // Estimator state kept by the bench.
  logic [SCORE_W-1:0]  est_score;
  logic [SCORE_W-1:0]  est_distance;
  logic [RATE_W-1:0]   est_rate;
  logic [COUNT_W-1:0]  est_misses;
  logic [PERIOD_W-1:0] est_phase;

  logic expected_hits[$];
  int   mismatch_count = 0;
  bit   idling_on = 1'b1;
  bit   hold_off_req = 1'b0;

  script_row_t script [19] = '{
    '{OP_ORDINARY,      1'b0, 2'd0, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_ORDINARY,      1'b1, 2'd3, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b0, 2'd0, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b0, 2'd1, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b0, 2'd2, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b0, 2'd3, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b0, 2'd0, 1'b0, 4'd1, 1'b1, 1'b1},
    '{OP_PERFECT_RESET, 1'b1, 2'd3, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_ORDINARY,      1'b0, 2'd0, 1'b0, 4'd7, 1'b0, 1'b0},
    '{OP_RECOVER,       1'b0, 2'd0, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_RECOVER,       1'b1, 2'd3, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_RECOVER,       1'b1, 2'd3, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_TICK,          1'b1, 2'd3, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_TICK,          1'b0, 2'd0, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_SPARE_A,       1'b1, 2'd3, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_SPARE_B,       1'b0, 2'd1, 1'b0, 4'd1, 1'b1, 1'b0},
    '{OP_SPARE_C,       1'b1, 2'd2, 1'b1, 4'd1, 1'b1, 1'b0},
    '{OP_CONTROL_FLOW,  1'b1, 2'd3, 1'b1, 4'd1, 1'b0, 1'b0},
    '{OP_ORDINARY,      1'b0, 2'd2, 1'b1, 4'd1, 1'b0, 1'b0}
  };

  // Saturating add into the score range.
  function automatic logic [SCORE_W-1:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(SCORE_MAX)) ? SCORE_MAX : s[SCORE_W-1:0];
  endfunction

  // Weight times sampled miss rate, moved from Q.8 to the score fraction.
  function automatic logic [63:0] weighted_miss_term();
    logic [63:0] p;
    p = 64'(set_weight) * 64'(est_rate);
    if (SCORE_FRAC_BITS >= RATE_FRAC) begin
      return p << (SCORE_FRAC_BITS - RATE_FRAC);
    end else begin
      return p >> (RATE_FRAC - SCORE_FRAC_BITS);
    end
  endfunction

  // Applies one event to the bench state and returns the flag it should produce.
  function automatic logic next_threshold_hit(input fe_event_t ev);
    logic [63:0] thr_fixed;
    logic [63:0] extra;
    logic [63:0] per;
    logic [63:0] quotient;
    logic        hit;
    thr_fixed = 64'(set_threshold) << SCORE_FRAC_BITS;
    extra     = weighted_miss_term();
    per       = (set_period == '0) ? 64'd1 : 64'(set_period);
    hit       = 1'b0;
    unique case (ev.opcode)
      OP_ORDINARY: begin
        if (!set_dist_off && !ev.is_cf) begin
          if (64'(est_distance) >= thr_fixed) begin
            est_score    = clamp_add(est_score,
                                     clamp_add(64'(set_increment) << SCORE_FRAC_BITS, extra));
            est_distance = '0;
          end else begin
            est_distance = clamp_add(est_distance, clamp_add(64'd1 << SCORE_FRAC_BITS, extra));
          end
        end
        hit = (64'(est_score) >= thr_fixed);
      end
      OP_CONTROL_FLOW: begin
        if (!set_cf_off) begin
          est_score    = clamp_add(est_score,
                                   clamp_add(64'(2'd3 - ev.conf) << SCORE_FRAC_BITS, extra));
          est_distance = '0;
        end
        hit = (64'(est_score) >= thr_fixed);
      end
      OP_TICK: begin
        // A window opens on phase zero: resample the rate, restart the miss count.
        if (est_phase == '0) begin
          quotient   = (64'(est_misses) << RATE_FRAC) / per;
          est_rate   = (quotient > 64'(RATE_ONE)) ? RATE_ONE : quotient[RATE_W-1:0];
          est_misses = '0;
        end
        est_phase = ((64'(est_phase) + 64'd1) >= per) ? '0 : est_phase + 1'b1;
      end
      OP_RECOVER: begin
        if (ev.miss && est_misses != '1) begin
          est_misses = est_misses + 1'b1;
        end
        est_score    = '0;
        est_distance = '0;
      end
      OP_PERFECT_RESET: begin
        est_distance = '0;
      end
      default: begin
      end
    endcase
    return hit;
  endfunction

  // Random event, weighted toward ops; every field bit is random regardless of opcode.
  function automatic fe_event_t random_event();
    fe_event_t ev;
    int        pick;
    pick     = $urandom_range(0, 99);
    ev.is_cf = ($urandom_range(0, 3) == 0);
    ev.conf  = 2'($urandom);
    ev.miss  = 1'($urandom);
    if (pick < 38) begin
      ev.opcode = OP_ORDINARY;
    end else if (pick < 62) begin
      ev.opcode = OP_CONTROL_FLOW;
    end else if (pick < 78) begin
      ev.opcode = OP_TICK;
    end else if (pick < 90) begin
      ev.opcode = OP_RECOVER;
    end else if (pick < 95) begin
      ev.opcode = OP_PERFECT_RESET;
    end else begin
      ev.opcode = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    return ev;
  endfunction

  // Offers one item, waits for it to be taken, and queues its expected flag.
  task automatic offer_event(input fe_event_t ev, input logic known, input logic known_hit);
    int   gap;
    logic predicted;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.opcode            <= ev.opcode;
    in_if.is_control_flow   <= ev.is_cf;
    in_if.branch_confidence <= ev.conf;
    in_if.was_btb_miss      <= ev.miss;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = next_threshold_hit(ev);
    expected_hits.push_back(known ? known_hit : predicted);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    unique case (idx)
      CFG_DIST_DISABLE: set_dist_off  = value[0];
      CFG_CF_DISABLE:   set_cf_off    = value[0];
      CFG_THRESHOLD:    set_threshold = value[THR_W-1:0];
      CFG_DIST_INCR:    set_increment = value[INCR_W-1:0];
      CFG_MISS_WEIGHT:  set_weight    = value[WEIGHT_W-1:0];
      CFG_PERIOD:       set_period    = value[PERIOD_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input bit dist_off, input bit cf_off, input int thr,
                                input int incr, input int weight, input int period);
    write_register(CFG_DIST_DISABLE, CFG_W'(dist_off));
    write_register(CFG_CF_DISABLE, CFG_W'(cf_off));
    write_register(CFG_THRESHOLD, CFG_W'(thr));
    write_register(CFG_DIST_INCR, CFG_W'(incr));
    write_register(CFG_MISS_WEIGHT, CFG_W'(weight));
    write_register(CFG_PERIOD, CFG_W'(period));
    cfg_we_i <= 1'b0;
  endtask

  // Compares one taken result with the oldest expectation.
  task automatic compare_result(input logic got);
    logic want;
    if (expected_hits.size() == 0) begin
      mismatch_count++;
      $display("%0t: result threshold_hit=%0b arrived with no item outstanding", $time, got);
    end else begin
      want = expected_hits.pop_front();
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: threshold_hit mismatch: expected %0b, actual %0b", $time, want, got);
      end
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: takes items, stalls in random bursts, and holds off once on request.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        compare_result(out_if.threshold_hit);
      end
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    fe_event_t ev;
    bit        dist_off;
    bit        cf_off;
    int        thr;
    int        incr;
    int        weight;
    int        period;

    rst_ni                  = 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_index_i             <= '0;
    cfg_data_i              <= '0;
    in_if.valid             <= 1'b0;
    in_if.opcode            <= OP_ORDINARY;
    in_if.is_control_flow   <= 1'b0;
    in_if.branch_confidence <= '0;
    in_if.was_btb_miss      <= 1'b0;

    // Register and state values after reset.
    set_dist_off  = 1'b0;
    set_cf_off    = 1'b0;
    set_threshold = THR_W'(8);
    set_increment = INCR_W'(1);
    set_weight    = '0;
    set_period    = PERIOD_W'(1000);
    est_score     = '0;
    est_distance  = '0;
    est_rate      = '0;
    est_misses    = '0;
    est_phase     = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings.
    foreach (script[i]) begin
      ev = '{script[i].opcode, script[i].is_cf, script[i].conf, script[i].miss};
      repeat (script[i].reps) offer_event(ev, script[i].known, script[i].hit);
    end
    drain();

    // Random phases, the first few at fixed corner settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          dist_off = 0; cf_off = 0; thr = 0; incr = 0; weight = 0; period = 1;
        end
        1: begin
          dist_off = 0; cf_off = 0; thr = 4095; incr = 255; weight = 255; period = 1;
        end
        2: begin
          dist_off = 1; cf_off = 1; thr = 5; incr = 7; weight = 128; period = 0;
        end
        3: begin
          dist_off = 0; cf_off = 0; thr = 20; incr = 255; weight = 255; period = 65535;
        end
        4: begin
          dist_off = 0; cf_off = 1; thr = 12; incr = 3; weight = 40; period = 1000;
        end
        5: begin
          // The period shrinks below the phase reached in the previous window.
          dist_off = 1; cf_off = 0; thr = 12; incr = 3; weight = 40; period = 3;
        end
        default: begin
          dist_off = ($urandom_range(0, 3) == 0);
          cf_off   = ($urandom_range(0, 3) == 0);
          thr      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 24);
          incr     = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 255);
          weight   = $urandom_range(0, 255);
          period   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 6);
        end
      endcase
      apply_settings(dist_off, cf_off, thr, incr, weight, period);
      idling_on = (p % 3 != 2) && (p != 3);
      // The result side holds off while items keep coming, so the block backs up.
      if (p == 3) begin
        hold_off_req = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) offer_event(random_event(), 1'b0, 1'b0);
      drain();
    end

    // Closing part without idling: drive the miss rate into saturation.
    idling_on = 1'b0;
    apply_settings(0, 0, 100, 2, 255, 1);
    ev = '{OP_TICK, 1'b0, 2'd0, 1'b0};
    offer_event(ev, 1'b0, 1'b0);
    drain();
    ev = '{OP_RECOVER, 1'b0, 2'd0, 1'b1};
    repeat (MISS_BURST) offer_event(ev, 1'b0, 1'b0);
    ev = '{OP_TICK, 1'b0, 2'd0, 1'b0};
    offer_event(ev, 1'b0, 1'b0);
    repeat (40) offer_event(random_event(), 1'b0, 1'b0);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/wbce_pkg.sv
src/wbce_if.sv
src/wbce_ctrl.sv
src/wbce_datapath.sv
src/weighted_branch_confidence_estimator.sv
bench/weighted_branch_confidence_estimator_test.sv
